>>> hw/rtl/vms_pkg.sv
// shared types and constants for the vector magnitude stream
`timescale 1ns / 1ps
package vms_pkg;

  localparam int unsigned SumBits   = 54;
  localparam int unsigned MagBits   = 27;
  localparam int unsigned SqrtCells = 27;

  typedef logic [SumBits-1:0] sum_t;
  typedef logic [MagBits-1:0] mag_t;

  localparam sum_t SumMax = '1;
  localparam mag_t MagMax = '1;

  typedef struct packed {
    logic saturated;
    sum_t rem;
    sum_t root;
  } sqrt_data_t;

endpackage

>>> hw/rtl/vms_sq_accum.sv
// squarer and saturating sum-of-squares accumulator
`timescale 1ns / 1ps
module vms_sq_accum #(
  parameter int unsigned ElementWidth = 24
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     fire_i,
  input  logic [ElementWidth-1:0]  element_i,
  input  logic                     last_i,
  output logic                     launch_valid_o,
  output vms_pkg::sqrt_data_t      launch_data_o
);
  import vms_pkg::*;

  localparam int unsigned SqW  = 2 * ElementWidth;
  localparam int unsigned AddW = ((SqW > SumBits) ? SqW : SumBits) + 1;

  logic [ElementWidth-1:0] abs_val;
  logic [SqW-1:0]          sq_d;
  logic [SqW-1:0]          sq_q;
  logic                    sq_vld_q;
  logic                    sq_last_q;
  sum_t                    sum_q;
  logic                    sat_q;
  logic [AddW-1:0]         sum_wide;
  logic                    ovf;
  sum_t                    sum_next;
  logic                    sat_next;

  // most negative value maps to 2^(w-1), which still fits unsigned
  assign abs_val = element_i[ElementWidth-1] ? (~element_i + ElementWidth'(1)) : element_i;
  assign sq_d    = abs_val * abs_val;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_vld_q  <= 1'b0;
      sq_last_q <= 1'b0;
    end else begin
      sq_vld_q  <= fire_i;
      sq_last_q <= fire_i & last_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      sq_q <= sq_d;
    end
  end

  assign sum_wide = AddW'(sum_q) + AddW'(sq_q);
  assign ovf      = sum_wide > AddW'(SumMax);
  assign sum_next = ovf ? SumMax : sum_wide[SumBits-1:0];
  assign sat_next = sat_q | ovf;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      sat_q <= 1'b0;
    end else if (sq_vld_q) begin
      if (sq_last_q) begin
        sum_q <= '0;
        sat_q <= 1'b0;
      end else begin
        sum_q <= sum_next;
        sat_q <= sat_next;
      end
    end
  end

  assign launch_valid_o = sq_vld_q & sq_last_q;
  assign launch_data_o  = '{saturated: sat_next, rem: sum_next, root: '0};

endmodule

>>> hw/rtl/vms_sqrt_cell.sv
// one restoring square root step, registered toward the next cell
`timescale 1ns / 1ps
module vms_sqrt_cell #(
  parameter int unsigned CellIdx = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  vms_pkg::sqrt_data_t data_i,
  output logic                valid_o,
  output vms_pkg::sqrt_data_t data_o
);
  import vms_pkg::*;

  localparam int unsigned BitPos = SumBits - 2 - 2 * CellIdx;
  localparam sum_t        BitVal = sum_t'(1) << BitPos;

  sum_t       cand;
  logic       take;
  sqrt_data_t data_d;
  sqrt_data_t data_q;
  logic       valid_q;

  assign cand = data_i.root + BitVal;
  assign take = data_i.rem >= cand;

  always_comb begin
    data_d.saturated = data_i.saturated;
    data_d.rem       = take ? (data_i.rem - cand) : data_i.rem;
    data_d.root      = take ? ((data_i.root >> 1) + BitVal) : (data_i.root >> 1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> hw/rtl/vector_magnitude_stream.sv
// Euclidean norm of a streamed vector: squares accumulate one element per cycle while a
// vector streams in; the element marked last closes the vector and its saturating 54-bit
// sum is handed to a row of 27 square root cells, one result bit per cell; the magnitude
// and the saturation flag pass the squarer register and each cell register on their way
// to the output register. Input is taken every cycle within a vector; after a last element
// the input stalls until its result is in the output register, and a further last element
// also waits while an earlier result has not been taken.
`timescale 1ns / 1ps
module vector_magnitude_stream #(
  parameter int unsigned ELEMENT_WIDTH = 24
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic signed [ELEMENT_WIDTH-1:0] element_i,
  input  logic                            last_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [vms_pkg::MagBits-1:0]     magnitude_o,
  output logic                            saturated_o
);
  import vms_pkg::*;

  logic       in_fire;
  logic       busy_q;
  logic       out_valid_q;
  mag_t       magnitude_q;
  logic       saturated_q;
  logic [SqrtCells:0] chain_vld;
  sqrt_data_t         chain_data [SqrtCells+1];

  assign in_ready_o = !busy_q && !(out_valid_q && last_i);
  assign in_fire    = in_valid_i && in_ready_o;

  vms_sq_accum #(
    .ElementWidth(ELEMENT_WIDTH)
  ) u_accum (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (in_fire),
    .element_i     (element_i),
    .last_i        (last_i),
    .launch_valid_o(chain_vld[0]),
    .launch_data_o (chain_data[0])
  );

  for (genvar g = 0; g < SqrtCells; g++) begin : g_cell
    vms_sqrt_cell #(
      .CellIdx(g)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(chain_vld[g]),
      .data_i (chain_data[g]),
      .valid_o(chain_vld[g+1]),
      .data_o (chain_data[g+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire && last_i) begin
        busy_q <= 1'b1;
      end else if (chain_vld[SqrtCells]) begin
        busy_q <= 1'b0;
      end
      // chain end never meets a full output register: last items wait for it
      if (chain_vld[SqrtCells]) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (chain_vld[SqrtCells]) begin
      magnitude_q <= chain_data[SqrtCells].root[MagBits-1:0];
      saturated_q <= chain_data[SqrtCells].saturated;
    end
  end

  assign out_valid_o = out_valid_q;
  assign magnitude_o = magnitude_q;
  assign saturated_o = saturated_q;

endmodule

>>> hw/rtl/vms_checker.sv
// port-level checks for the vector magnitude stream, bound to the top level
`timescale 1ns / 1ps
module vms_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        last_i,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [vms_pkg::MagBits-1:0] magnitude_o,
  input logic                        saturated_o
);
  import vms_pkg::*;

  // a held result keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(magnitude_o)
      && $stable(saturated_o))
    else $error("output item changed while stalled");

  // a closed vector blocks input right after its last item is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && last_i |=> !in_ready_o)
    else $error("input taken right after last item");

  // a new result only comes out of a busy period
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result without a pending vector");

  // a saturated sum always roots to the top value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |-> magnitude_o == MagMax)
    else $error("saturated item with wrong magnitude");

endmodule

bind vector_magnitude_stream vms_checker u_vms_checker (.*);

>>> tb/testbench.sv
// testbench for vector_magnitude_stream: directed and random vectors against a sum-of-squares predictor
`timescale 1ns / 1ps
module testbench;
  import vms_pkg::*;

  localparam int ElemW        = 24;
  localparam int WatchdogLimit = 4000;
  localparam int HoldOffCycles = 400;
  localparam int DrainCycles   = 40;

  typedef struct {
    logic signed [ElemW-1:0] element;
    logic                    last;
  } vec_item_t;

  typedef struct {
    mag_t magnitude;
    logic saturated;
  } norm_t;

  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_COIN,
    RX_SLOW
  } rx_mode_e;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  logic signed [ElemW-1:0] element_i = '0;
  logic                    last_i = 1'b0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  mag_t                    magnitude_o;
  logic                    saturated_o;

  vector_magnitude_stream #(
    .ELEMENT_WIDTH(ElemW)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .element_i  (element_i),
    .last_i     (last_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .magnitude_o(magnitude_o),
    .saturated_o(saturated_o)
  );

  always #4 clk_i = ~clk_i;

  vec_item_t pending_q[$];
  norm_t     norm_expected_q[$];

  // predictor state
  sum_t sum_sq = '0;
  logic sum_sat = 1'b0;

  int   mismatches = 0;
  int   results_seen = 0;
  int   elems_seen = 0;
  int   sat_vectors = 0;
  int   longest_vec = 0;
  int   cur_len = 0;
  int   idle_cycles = 0;
  logic in_taken = 1'b0;

  function automatic mag_t floor_root(sum_t v);
    longint unsigned r;
    longint unsigned c;
    r = 0;
    for (int i = MagBits - 1; i >= 0; i--) begin
      c = r | (64'd1 << i);
      if (c * c <= 64'(v)) r = c;
    end
    return r[MagBits-1:0];
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t: mismatch: %s", $realtime, msg);
  endtask

  task automatic queue_item(input logic signed [ElemW-1:0] e, input logic l);
    vec_item_t it;
    it.element = e;
    it.last    = l;
    pending_q.push_back(it);
  endtask

  function automatic logic signed [ElemW-1:0] rand_element();
    logic signed [ElemW-1:0] e;
    case ($urandom_range(0, 5))
      0, 1, 2: e = ElemW'($urandom);
      3: e = ElemW'($urandom_range(0, 511) - 256);
      4: begin
        case ($urandom_range(0, 3))
          0: e = {1'b1, {(ElemW-1){1'b0}}};
          1: e = {1'b0, {(ElemW-1){1'b1}}};
          2: e = '0;
          default: e = '1;
        endcase
      end
      default: e = {$urandom_range(0, 1) ? 2'b11 : 2'b00, 22'($urandom)};
    endcase
    return e;
  endfunction

  // element close to full scale, so long vectors run into saturation
  function automatic logic signed [ElemW-1:0] heavy_element();
    int unsigned m;
    m = $urandom_range(32'h80_0000 - 32'h1_0000, 32'h80_0000);
    return $urandom_range(0, 1) ? ElemW'(-m) : ElemW'(m);
  endfunction

  // sender: bursts of items separated by random gaps
  int burst_left = 0;
  int gap_left = 0;

  always @(negedge clk_i) begin
    vec_item_t it;
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 48);
        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      end
      if (gap_left != 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (pending_q.size() != 0) begin
        it = pending_q.pop_front();
        burst_left--;
        in_valid_i <= 1'b1;
        element_i  <= it.element;
        last_i     <= it.last;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver: random stall pattern plus long hold-offs to back up the block
  rx_mode_e rx_mode = RX_ALWAYS;
  int       phase_left = 0;
  int       hold_left = 0;
  int       hold_at = 6;
  int       holds_done = 0;

  always @(negedge clk_i) begin
    logic rdy;
    rdy = 1'b0;
    if (rst_ni) begin
      if (hold_left == 0 && holds_done < 2 && results_seen >= hold_at) begin
        hold_left = HoldOffCycles;
        holds_done++;
        hold_at = 40;
      end
      if (hold_left != 0) begin
        hold_left--;
      end else begin
        if (phase_left == 0) begin
          phase_left = $urandom_range(10, 80);
          rx_mode    = rx_mode_e'($urandom_range(0, 2));
        end
        phase_left--;
        case (rx_mode)
          RX_ALWAYS: rdy = 1'b1;
          RX_COIN:   rdy = 1'($urandom_range(0, 1));
          default:   rdy = ($urandom_range(0, 3) == 0);
        endcase
      end
      out_ready_i <= rdy;
    end
  end

  // monitor, predictor and watchdog
  always @(posedge clk_i) begin
    norm_t           exp_n;
    longint          e;
    longint unsigned m;
    longint unsigned sq;
    in_taken <= in_valid_i && in_ready_o;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (norm_expected_q.size() == 0) begin
          report_mismatch($sformatf("result with nothing pending: magnitude %0d saturated %0b",
                                    magnitude_o, saturated_o));
        end else begin
          exp_n = norm_expected_q.pop_front();
          if (magnitude_o !== exp_n.magnitude)
            report_mismatch($sformatf("magnitude expected %0d actual %0d",
                                      exp_n.magnitude, magnitude_o));
          if (saturated_o !== exp_n.saturated)
            report_mismatch($sformatf("saturated expected %0b actual %0b (magnitude %0d)",
                                      exp_n.saturated, saturated_o, exp_n.magnitude));
        end
      end
      if (in_valid_i && in_ready_o) begin
        elems_seen++;
        cur_len++;
        e  = longint'(element_i);
        m  = (e < 0) ? longint'(-e) : longint'(e);
        sq = m * m;
        if (sq > 64'(SumMax - sum_sq)) begin
          sum_sq  = SumMax;
          sum_sat = 1'b1;
        end else begin
          sum_sq = sum_sq + sq[SumBits-1:0];
        end
        if (last_i) begin
          exp_n.magnitude = floor_root(sum_sq);
          exp_n.saturated = sum_sat;
          norm_expected_q.push_back(exp_n);
          if (sum_sat) sat_vectors++;
          if (cur_len > longest_vec) longest_vec = cur_len;
          cur_len = 0;
          sum_sq  = '0;
          sum_sat = 1'b0;
        end
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WatchdogLimit) begin
          $display("%0t: no item moved for %0d cycles", $realtime, WatchdogLimit);
          $display("Testbench completed WITH ERRORS");
          $finish;
        end
      end
    end
  end

  initial begin
    int n_items;
    int n_vectors;
    int len;
    int kind;
    logic heavy;

    // directed vectors: extremes, a classic triangle, bit patterns
    queue_item(24'sd0, 1'b1);
    queue_item(-24'sd8388608, 1'b1);
    queue_item(24'sd8388607, 1'b1);
    queue_item(-24'sd1, 1'b1);
    queue_item(24'sd3, 1'b0);
    queue_item(-24'sd4, 1'b1);
    queue_item(24'sd1, 1'b0);
    queue_item(24'sd1, 1'b0);
    queue_item(-24'sd1, 1'b0);
    queue_item(24'sd1, 1'b1);
    queue_item(24'sd2, 1'b0);
    queue_item(24'sd3, 1'b1);
    queue_item(-24'sd8388608, 1'b0);
    queue_item(-24'sd8388608, 1'b0);
    queue_item(24'sd8388607, 1'b0);
    queue_item(24'sd8388607, 1'b1);
    queue_item(24'h555555, 1'b0);
    queue_item(24'hAAAAAA, 1'b1);
    queue_item(24'sd0, 1'b0);
    queue_item(24'sd0, 1'b0);
    queue_item(24'sd7, 1'b1);

    // random vectors, the first one long and near full scale to hit saturation
    n_items   = 0;
    n_vectors = 0;
    heavy     = 1'b1;
    while (n_items < 1100 || n_vectors < 60) begin
      if (heavy) begin
        len = $urandom_range(230, 300);
      end else begin
        kind = $urandom_range(0, 19);
        if (kind < 14) len = $urandom_range(1, 8);
        else if (kind < 19) len = $urandom_range(9, 64);
        else len = $urandom_range(65, 120);
      end
      for (int i = 0; i < len; i++)
        queue_item(heavy ? heavy_element() : rand_element(), i == len - 1);
      n_items += len;
      n_vectors++;
      heavy = ($urandom_range(0, 59) == 0);
    end

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_q.size() != 0 || in_valid_i || norm_expected_q.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("streamed %0d elements, %0d vectors checked, longest vector %0d elements",
             elems_seen, results_seen, longest_vec);
    $display("%0d vectors saturated, %0d mismatches", sat_vectors, mismatches);
    if (mismatches == 0 && norm_expected_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
